// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication that is checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== design/hpk_pkg.sv =====
// ----------------------------------------------------------------------------
// HPACK header block parser package
// Types, codes and sizes shared by the parser core, its parts and its checker.
// ----------------------------------------------------------------------------
package hpk_pkg;

   // Continuation bytes allowed after a full prefix.
   localparam int MAX_CONT_BYTES = 4;
   localparam int CNT_W          = $clog2(MAX_CONT_BYTES + 1);
   localparam int SHIFT_W        = $clog2(7 * MAX_CONT_BYTES + 1);
   // Prefix plus every continuation group fits in this many bits.
   localparam int ACC_W          = 7 * MAX_CONT_BYTES + 1;
   localparam int STATIC_ENTRIES = 62;

   // Result queue size.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_INDEXED    = 3'd0;
   localparam kind_type KIND_NAME_INDEX = 3'd1;
   localparam kind_type KIND_NAME_BYTE  = 3'd2;
   localparam kind_type KIND_VALUE_BYTE = 3'd3;
   localparam kind_type KIND_BLOCK_OK   = 3'd4;
   localparam kind_type KIND_ERROR      = 3'd5;

   typedef logic [2:0] error_type;
   localparam error_type ERR_NONE        = 3'd0;
   localparam error_type ERR_BAD_INDEX   = 3'd1;
   localparam error_type ERR_HUFFMAN     = 3'd2;
   localparam error_type ERR_UNSUPPORTED = 3'd3;
   localparam error_type ERR_TRUNCATED   = 3'd4;
   localparam error_type ERR_OVERFLOW    = 3'd5;

   typedef enum logic [6:0] {
      PH_START     = 7'b0000001,
      PH_IDX_CONT  = 7'b0000010,
      PH_NIDX_CONT = 7'b0000100,
      PH_LEN_FIRST = 7'b0001000,
      PH_LEN_CONT  = 7'b0010000,
      PH_DATA      = 7'b0100000,
      PH_SKIP      = 7'b1000000
   } phase_type;

   typedef struct packed {
      kind_type  kind;
      logic [5:0] table_index;
      logic [7:0] out_byte;
      logic      byte_valid;
      logic      string_end;
      logic      field_end;
      error_type error_code;
   } result_type;

   typedef struct packed {
      phase_type          phase;
      logic [ACC_W-1:0]   int_accum;
      logic [SHIFT_W-1:0] shift_count;
      logic [CNT_W-1:0]   cont_count;
      logic [ACC_W-1:0]   bytes_left;
      logic               in_value_string;
   } state_type;

   // Results that one header byte produces, oldest first.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

   function automatic result_type make_result(kind_type k, logic [5:0] idx, logic [7:0] ob,
                                              logic bv, logic se, logic fe, error_type ec);
      result_type r;
      r.kind        = k;
      r.table_index = idx;
      r.out_byte    = ob;
      r.byte_valid  = bv;
      r.string_end  = se;
      r.field_end   = fe;
      r.error_code  = ec;
      return r;
   endfunction

endpackage

// ===== design/hpack_header_block_parser_core.sv =====
// ----------------------------------------------------------------------------
// HPACK header block parser core
// Parses a static-table HPACK header block one byte at a time and streams
// out indexed fields, name indexes, string bytes and a block end or error report.
//
//   Channel | Direction | Handshake           | Word
//   req     | in        | req_valid/req_ready | one header block byte, last flag
//   rsp     | out       | rsp_valid/rsp_ready | one parse result
//
// A byte is decoded in the cycle it is accepted and its results land in a
// four-word result queue.
// One byte is taken each cycle while the queue has room for two words, as a
// byte that also closes the block pushes two result words.
// A stalled rsp side fills the queue and then holds req_ready low.
// Synchronous reset returns the parser to the start of a field and empties
// the queue.
// ----------------------------------------------------------------------------
module hpack_header_block_parser_core
   import hpk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_block_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [5:0] rsp_table_index,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_end,
   output logic       rsp_field_end,
   output logic [2:0] rsp_error_code
);

   state_type    state_ff;
   state_type    state_in;
   state_type    step_nxt;
   step_out_type step_out;
   step_out_type push;
   result_type   head;
   logic         accept;
   logic         room_two;

   assign accept = req_valid && req_ready;

   // Byte decoder.
   hpk_step u_step (
      .state_cur  (state_ff),
      .in_byte    (req_in_byte),
      .block_last (req_block_last),
      .state_nxt  (step_nxt),
      .step_out   (step_out)
   );

   // Parser state advances only on an accepted word.
   assign state_in = accept ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= PH_START;
         state_ff.int_accum       <= '0;
         state_ff.shift_count     <= '0;
         state_ff.cont_count      <= '0;
         state_ff.bytes_left      <= '0;
         state_ff.in_value_string <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Results of an accepted word go into the queue.
   always_comb begin
      push       = step_out;
      push.count = accept ? step_out.count : 2'd0;
   end

   hpk_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ready),
      .head      (head),
      .not_empty (rsp_valid),
      .room_two  (room_two)
   );

   assign req_ready = room_two;

   // Result ports.
   assign rsp_kind        = head.kind;
   assign rsp_table_index = head.table_index;
   assign rsp_out_byte    = head.out_byte;
   assign rsp_byte_valid  = head.byte_valid;
   assign rsp_string_end  = head.string_end;
   assign rsp_field_end   = head.field_end;
   assign rsp_error_code  = head.error_code;

endmodule

// ===== design/hpk_step.sv =====
// ----------------------------------------------------------------------------
// HPACK parser step
// Decodes one header byte against the parser state: gives the next state and
// up to two results (the byte's own result and a block end or error report).
// ----------------------------------------------------------------------------
module hpk_step
   import hpk_pkg::*;
(
   input  state_type    state_cur,
   input  logic [7:0]   in_byte,
   input  logic         block_last,
   output state_type    state_nxt,
   output step_out_type step_out
);

   state_type          nxt;
   error_type          err;
   logic               body_ev;
   result_type         body_res;
   logic               fin_ev;
   result_type         fin_res;
   logic               idx_ev;
   logic               nidx_ev;
   logic               len_ev;
   logic [ACC_W-1:0]   val;
   logic [ACC_W-1:0]   cont_sum;
   logic [CNT_W-1:0]   cont_inc;
   logic [ACC_W-1:0]   left_dec;
   logic               is_lit6;
   logic [5:0]         lit_prefix;
   logic               lit_full;
   logic               val_bad;

   // Shared arithmetic for continuation bytes and string data.
   assign cont_sum = state_cur.int_accum + (ACC_W'(in_byte[6:0]) << state_cur.shift_count);
   assign cont_inc = state_cur.cont_count + CNT_W'(1);
   assign left_dec = state_cur.bytes_left - ACC_W'(1);

   // Literal prefix: six bits for incremental indexing, four otherwise.
   assign is_lit6    = (in_byte[7:6] == 2'b01);
   assign lit_prefix = is_lit6 ? in_byte[5:0] : {2'b00, in_byte[3:0]};
   assign lit_full   = is_lit6 ? (in_byte[5:0] == 6'h3F) : (in_byte[3:0] == 4'hF);

   always_comb begin
      nxt      = state_cur;
      err      = ERR_NONE;
      body_ev  = 1'b0;
      body_res = '0;
      fin_ev   = 1'b0;
      fin_res  = '0;
      idx_ev   = 1'b0;
      nidx_ev  = 1'b0;
      len_ev   = 1'b0;
      val      = '0;
      val_bad  = 1'b0;

      // Per-phase decoding of the byte.
      unique case (state_cur.phase)
         PH_START: begin
            if (in_byte[7]) begin
               if (in_byte[6:0] != 7'h7F) begin
                  idx_ev = 1'b1;
                  val    = ACC_W'(in_byte[6:0]);
               end else begin
                  nxt.int_accum   = ACC_W'(in_byte[6:0]);
                  nxt.shift_count = '0;
                  nxt.cont_count  = '0;
                  nxt.phase       = PH_IDX_CONT;
               end
            end else if (is_lit6 || (in_byte[7:5] == 3'b000)) begin
               if (lit_prefix == 6'd0) begin
                  nxt.in_value_string = 1'b0;
                  nxt.phase           = PH_LEN_FIRST;
               end else if (!lit_full) begin
                  nidx_ev = 1'b1;
                  val     = ACC_W'(lit_prefix);
               end else begin
                  nxt.int_accum   = ACC_W'(lit_prefix);
                  nxt.shift_count = '0;
                  nxt.cont_count  = '0;
                  nxt.phase       = PH_NIDX_CONT;
               end
            end else begin
               err = ERR_UNSUPPORTED;
            end
         end
         PH_IDX_CONT, PH_NIDX_CONT, PH_LEN_CONT: begin
            nxt.int_accum   = cont_sum;
            nxt.cont_count  = cont_inc;
            nxt.shift_count = state_cur.shift_count + SHIFT_W'(7);
            if (in_byte[7]) begin
               if (cont_inc >= CNT_W'(MAX_CONT_BYTES)) begin
                  err = ERR_OVERFLOW;
               end
            end else begin
               val = cont_sum;
               if (state_cur.phase == PH_IDX_CONT) begin
                  idx_ev = 1'b1;
               end else if (state_cur.phase == PH_NIDX_CONT) begin
                  nidx_ev = 1'b1;
               end else begin
                  len_ev = 1'b1;
               end
            end
         end
         PH_LEN_FIRST: begin
            if (in_byte[7]) begin
               err = ERR_HUFFMAN;
            end else if (in_byte[6:0] != 7'h7F) begin
               len_ev = 1'b1;
               val    = ACC_W'(in_byte[6:0]);
            end else begin
               nxt.int_accum   = ACC_W'(7'h7F);
               nxt.shift_count = '0;
               nxt.cont_count  = '0;
               nxt.phase       = PH_LEN_CONT;
            end
         end
         PH_DATA: begin
            nxt.bytes_left = left_dec;
            body_ev        = 1'b1;
            if (left_dec == '0) begin
               if (state_cur.in_value_string) begin
                  body_res = make_result(KIND_VALUE_BYTE, 6'd0, in_byte, 1'b1, 1'b1, 1'b1,
                                         ERR_NONE);
                  nxt.in_value_string = 1'b0;
                  nxt.phase           = PH_START;
               end else begin
                  body_res = make_result(KIND_NAME_BYTE, 6'd0, in_byte, 1'b1, 1'b1, 1'b0,
                                         ERR_NONE);
                  nxt.in_value_string = 1'b1;
                  nxt.phase           = PH_LEN_FIRST;
               end
            end else begin
               body_res = make_result(state_cur.in_value_string ? KIND_VALUE_BYTE
                                                                : KIND_NAME_BYTE,
                                      6'd0, in_byte, 1'b1, 1'b0, 1'b0, ERR_NONE);
            end
         end
         PH_SKIP: begin
            nxt.phase = PH_SKIP;
         end
         default: begin
            nxt.phase = PH_SKIP;
         end
      endcase

      // A decoded index must name a static table entry.
      val_bad = (val == '0) || (val >= ACC_W'(STATIC_ENTRIES));

      // Completed integers: indexed field, name index or string length.
      if (idx_ev) begin
         if (val_bad) begin
            err = ERR_BAD_INDEX;
         end else begin
            body_ev         = 1'b1;
            body_res        = make_result(KIND_INDEXED, val[5:0], 8'd0, 1'b0, 1'b0, 1'b1,
                                          ERR_NONE);
            nxt.int_accum   = '0;
            nxt.shift_count = '0;
            nxt.cont_count  = '0;
            nxt.phase       = PH_START;
         end
      end
      if (nidx_ev) begin
         if (val_bad) begin
            err = ERR_BAD_INDEX;
         end else begin
            body_ev             = 1'b1;
            body_res            = make_result(KIND_NAME_INDEX, val[5:0], 8'd0, 1'b0, 1'b0,
                                              1'b0, ERR_NONE);
            nxt.int_accum       = '0;
            nxt.shift_count     = '0;
            nxt.cont_count      = '0;
            nxt.in_value_string = 1'b1;
            nxt.phase           = PH_LEN_FIRST;
         end
      end
      if (len_ev) begin
         nxt.int_accum   = '0;
         nxt.shift_count = '0;
         nxt.cont_count  = '0;
         if (val != '0) begin
            nxt.bytes_left = val;
            nxt.phase      = PH_DATA;
         end else if (state_cur.in_value_string) begin
            body_ev             = 1'b1;
            body_res            = make_result(KIND_VALUE_BYTE, 6'd0, 8'd0, 1'b0, 1'b1, 1'b1,
                                              ERR_NONE);
            nxt.in_value_string = 1'b0;
            nxt.phase           = PH_START;
         end else begin
            body_ev             = 1'b1;
            body_res            = make_result(KIND_NAME_BYTE, 6'd0, 8'd0, 1'b0, 1'b1, 1'b0,
                                              ERR_NONE);
            nxt.in_value_string = 1'b1;
            nxt.phase           = PH_LEN_FIRST;
         end
      end

      // Error report, or end of block report on the final byte.
      if (err != ERR_NONE) begin
         fin_ev              = 1'b1;
         fin_res             = make_result(KIND_ERROR, 6'd0, 8'd0, 1'b0, 1'b0, 1'b0, err);
         nxt.int_accum       = '0;
         nxt.shift_count     = '0;
         nxt.cont_count      = '0;
         nxt.bytes_left      = '0;
         nxt.in_value_string = 1'b0;
         nxt.phase           = block_last ? PH_START : PH_SKIP;
      end else if (block_last) begin
         if (nxt.phase == PH_START) begin
            fin_ev  = 1'b1;
            fin_res = make_result(KIND_BLOCK_OK, 6'd0, 8'd0, 1'b0, 1'b0, 1'b0, ERR_NONE);
         end else if (nxt.phase != PH_SKIP) begin
            fin_ev  = 1'b1;
            fin_res = make_result(KIND_ERROR, 6'd0, 8'd0, 1'b0, 1'b0, 1'b0, ERR_TRUNCATED);
         end
         nxt.int_accum       = '0;
         nxt.shift_count     = '0;
         nxt.cont_count      = '0;
         nxt.bytes_left      = '0;
         nxt.in_value_string = 1'b0;
         nxt.phase           = PH_START;
      end
   end

   // Pack the results in order.
   always_comb begin
      step_out.count  = 2'(body_ev) + 2'(fin_ev);
      step_out.first  = body_ev ? body_res : fin_res;
      step_out.second = fin_res;
   end

   assign state_nxt = nxt;

endmodule

// ===== design/hpk_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// HPACK result queue
// Small queue that takes up to two result words a cycle and hands out one.
// ----------------------------------------------------------------------------
module hpk_rsp_fifo
   import hpk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  step_out_type push,
   input  logic         pop,
   output result_type   head,
   output logic         not_empty,
   output logic         room_two
);

   result_type           mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff;
   logic [RSP_CNT_W-1:0] count_in;
   logic                 do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign not_empty = (count_ff != '0);
   assign room_two  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign head      = mem_ff[rd_ptr_ff];

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(do_pop);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage; the entries need no reset.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.second;
      end
   end

endmodule

// ===== design/hpk_checker.sv =====
// ----------------------------------------------------------------------------
// HPACK parser port checker
// Watches the parser core's ports and checks result coding, queue hold and reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpk_checker
   import hpk_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [5:0] rsp_table_index,
   input logic       rsp_byte_valid,
   input logic       rsp_field_end,
   input logic [2:0] rsp_error_code
);

   // An indexed field names a real table entry and closes a field.
   `ASSERT_IMPLY(a_indexed_ok, clock, reset, rsp_valid && (rsp_kind == KIND_INDEXED), (rsp_table_index != 6'd0) && (rsp_table_index < 6'(STATIC_ENTRIES)) && rsp_field_end)

   // Only an error word carries an error code, and it always carries one.
   `ASSERT_IMPLY(a_error_code, clock, reset, rsp_valid, (rsp_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE))

   // Byte data is only marked valid on string words.
   `ASSERT_IMPLY(a_byte_kind, clock, reset, rsp_valid && rsp_byte_valid, (rsp_kind == KIND_NAME_BYTE) || (rsp_kind == KIND_VALUE_BYTE))

   // A stalled result stays offered with the same coding.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_error_code))

   // Reset empties the result queue.
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind hpack_header_block_parser_core hpk_checker u_hpk_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_table_index (rsp_table_index),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_field_end   (rsp_field_end),
   .rsp_error_code  (rsp_error_code)
);
